### rtl/cb64e_pkg.sv
`timescale 1ns / 1ps

package cb64e_pkg;

    // Fixed field widths of the ports.
    localparam int unsigned CFG_W   = 13;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned NEED_W  = 14;
    localparam int unsigned GROUP_W = 13;

    localparam int unsigned MAX_OUT_SIZE_DEF = 4096;

    // Group counter saturates here; four times it saturates the length field.
    localparam logic [GROUP_W-1:0] GROUP_MAX = 13'h1FFF;
    localparam logic [NEED_W-1:0]  NEED_MAX  = 14'h3FFF;

    localparam logic [BYTE_W-1:0] SEP_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] PAD_CHAR  = 7'h3D;

    // Padding modes of one group: full, one pad, two pads.
    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [1:0]        cnt;
    } hold_t;

    // Index 0 is the first character of the group.
    typedef logic [3:0][CHAR_W-1:0] quad_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd26) begin
            c = 7'(v) + 7'd65;
        end else if (v < 6'd52) begin
            c = 7'(v) + 7'd71;
        end else if (v < 6'd62) begin
            c = 7'(v) - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

    function automatic quad_t group_chars(input logic [BYTE_W-1:0] b0,
                                          input logic [BYTE_W-1:0] b1,
                                          input logic [BYTE_W-1:0] b2,
                                          input logic [1:0]        fill);
        quad_t q;
        q[0] = b64_char(b0[7:2]);
        q[1] = b64_char({b0[1:0], b1[7:4]});
        q[2] = (fill == FILL_TWO) ? PAD_CHAR : b64_char({b1[3:0], b2[7:6]});
        q[3] = (fill != FILL_NONE) ? PAD_CHAR : b64_char(b2[5:0]);
        return q;
    endfunction

    // Adds one byte to the held bytes; a third byte completes a group and empties them.
    function automatic hold_t push_hold(input hold_t h, input logic [BYTE_W-1:0] b);
        hold_t r;
        r = h;
        case (h.cnt)
            2'd0: begin
                r.b0  = b;
                r.cnt = 2'd1;
            end
            2'd1: begin
                r.b1  = b;
                r.cnt = 2'd2;
            end
            default: begin
                r.cnt = 2'd0;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/credential_base64_encoder_core.sv
`timescale 1ns / 1ps

// Base64 encoder for a "user:password" credential stream. User-name bytes
// come first, then password bytes; the block inserts the ':' separator
// before the first password byte (or at the end of the stream when no
// password byte came and bytes are still held), encodes each group of three
// bytes into four characters, and pads the final group with '='. One output
// transaction carries one character. Characters at position out_size-1 and
// beyond are dropped, but every group still counts four toward
// needed_length, which is reported on the final transaction of an item with
// last set; such an item always gives at least one transaction (with
// char_valid low when it wrote nothing). An item without last that writes
// nothing gives no output transaction. Timing: an accepted item is held in
// the input register, then all of its characters are computed in a single
// pass and loaded into an eight-entry result buffer that is sent one
// character per cycle while m_ready is high. An item gives at most eight
// output transactions and holds the buffer until its final one is taken;
// the next item is loaded in the same cycle that the previous item's final
// transaction is taken, so items that give zero or one transaction stream
// at one per cycle while m_ready is high. Configuration is written through
// the cfg channel, which is always ready, and must only be written while idle.

module credential_base64_encoder_core #(
    parameter int unsigned MAX_OUT_SIZE = cb64e_pkg::MAX_OUT_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cb64e_pkg::CFG_W-1:0]    cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cb64e_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                           s_is_password,
    input  logic                           s_has_byte,
    input  logic                           s_last,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cb64e_pkg::CHAR_W-1:0]   m_out_char,
    output logic                           m_char_valid,
    output logic [cb64e_pkg::NEED_W-1:0]   m_needed_length,
    output logic                           m_last_of_run
);

    import cb64e_pkg::*;

    // Wide enough to hold the clamped buffer size and the characters written.
    localparam int unsigned SIZE_W = $clog2(MAX_OUT_SIZE + 1);

    // Configured buffer size, already clamped to MAX_OUT_SIZE.
    logic [SIZE_W-1:0] size_reg, size_next;

    // Input register.
    logic              a_valid_reg, a_valid_next;
    logic [BYTE_W-1:0] a_data_reg;
    logic              a_pw_reg;
    logic              a_has_reg;
    logic              a_last_reg;

    // Encoder state of the running credential.
    hold_t              hold_reg, hold_next;
    logic               sep_reg, sep_next;
    logic [SIZE_W-1:0]  cw_reg, cw_next;
    logic [GROUP_W-1:0] gt_reg, gt_next;

    // Result buffer: characters of one item, sent in order.
    logic [7:0][CHAR_W-1:0] char_reg, char_next;
    logic [3:0]             left_reg, left_next;
    logic [2:0]             idx_reg, idx_next;
    logic                   has_chars_reg, has_chars_next;
    logic                   out_last_reg, out_last_next;
    logic [NEED_W-1:0]      need_reg, need_next;

    // Single-pass encoding of the item in the input register.
    hold_t        h_b, h_c;
    logic         sep_pw, sep_run, sep_last;
    logic         grp_a_vld, grp_b_vld;
    logic [BYTE_W-1:0] ga0, ga1, ga2, gb0, gb1, gb2;
    logic [1:0]   gb_fill;
    quad_t        quad_a, quad_b;
    logic [3:0]   n_gen, n_wr;
    logic [SIZE_W:0] cw_p1, room;
    logic [GROUP_W:0] gt_sum;
    logic [GROUP_W-1:0] gt_new;
    logic [NEED_W-1:0]  need_new;

    logic buf_free, a_move, out_take;

    assign cfg_ready = 1'b1;

    assign out_take = m_valid && m_ready;
    assign buf_free = (left_reg == 4'd0) || ((left_reg == 4'd1) && m_ready);
    assign a_move   = a_valid_reg && buf_free;
    assign s_ready  = !a_valid_reg || a_move;

    always_comb begin
        // A password byte ahead of the separator first pushes ':'.
        sep_pw    = a_has_reg && a_pw_reg && !sep_reg;
        grp_a_vld = 1'b0;
        ga0       = hold_reg.b0;
        ga1       = hold_reg.b1;
        ga2       = SEP_COLON;
        h_b       = hold_reg;
        if (sep_pw) begin
            if (hold_reg.cnt == 2'd2) begin
                grp_a_vld = 1'b1;
            end
            h_b = push_hold(hold_reg, SEP_COLON);
        end
        h_c = h_b;
        if (a_has_reg) begin
            if (h_b.cnt == 2'd2) begin
                grp_a_vld = 1'b1;
                ga0       = h_b.b0;
                ga1       = h_b.b1;
                ga2       = a_data_reg;
            end
            h_c = push_hold(h_b, a_data_reg);
        end
        sep_run = sep_reg || sep_pw;

        // End of stream: late separator if bytes are held, then the padded group.
        sep_last  = a_last_reg && !sep_run && (h_c.cnt != 2'd0);
        grp_b_vld = 1'b0;
        gb0       = h_c.b0;
        gb1       = h_c.b1;
        gb2       = '0;
        gb_fill   = FILL_NONE;
        if (a_last_reg && (h_c.cnt == 2'd2)) begin
            grp_b_vld = 1'b1;
            if (sep_last) begin
                gb2 = SEP_COLON;
            end else begin
                gb_fill = FILL_ONE;
            end
        end else if (a_last_reg && (h_c.cnt == 2'd1)) begin
            grp_b_vld = 1'b1;
            if (sep_last) begin
                gb1     = SEP_COLON;
                gb_fill = FILL_ONE;
            end else begin
                gb1     = '0;
                gb_fill = FILL_TWO;
            end
        end

        quad_a = group_chars(ga0, ga1, ga2, FILL_NONE);
        quad_b = group_chars(gb0, gb1, gb2, gb_fill);
        n_gen  = {1'b0, ({1'b0, grp_a_vld} + {1'b0, grp_b_vld}), 1'b0} << 1;

        // Characters still allowed before the buffer limit.
        cw_p1 = {1'b0, cw_reg} + {{SIZE_W{1'b0}}, 1'b1};
        if ({1'b0, size_reg} > cw_p1) begin
            room = {1'b0, size_reg} - cw_p1;
        end else begin
            room = '0;
        end
        if (room < (SIZE_W+1)'(n_gen)) begin
            n_wr = room[3:0];
        end else begin
            n_wr = n_gen;
        end

        gt_sum = {1'b0, gt_reg} + (GROUP_W+1)'(grp_a_vld) + (GROUP_W+1)'(grp_b_vld);
        gt_new = (gt_sum > {1'b0, GROUP_MAX}) ? GROUP_MAX : gt_sum[GROUP_W-1:0];
        // Four per group; 4096 groups or more overflow the length field.
        need_new = gt_new[GROUP_W-1] ? NEED_MAX : {gt_new[GROUP_W-2:0], 2'b00};
    end

    always_comb begin
        size_next = size_reg;
        if (cfg_valid) begin
            if (32'(cfg_data) > 32'(MAX_OUT_SIZE)) begin
                size_next = SIZE_W'(MAX_OUT_SIZE);
            end else begin
                size_next = SIZE_W'(cfg_data);
            end
        end

        a_valid_next = a_valid_reg;
        if (s_valid && s_ready) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end

        hold_next      = hold_reg;
        sep_next       = sep_reg;
        cw_next        = cw_reg;
        gt_next        = gt_reg;
        char_next      = char_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;
        has_chars_next = has_chars_reg;
        out_last_next  = out_last_reg;
        need_next      = need_reg;

        if (a_move) begin
            // The first group found always goes first in the buffer.
            char_next[3:0] = grp_a_vld ? quad_a : quad_b;
            char_next[7:4] = quad_b;
            idx_next       = 3'd0;
            has_chars_next = (n_wr != 4'd0);
            out_last_next  = a_last_reg;
            need_next      = need_new;
            if (n_wr != 4'd0) begin
                left_next = n_wr;
            end else if (a_last_reg) begin
                left_next = 4'd1;
            end else begin
                left_next = 4'd0;
            end
            if (a_last_reg) begin
                hold_next = '0;
                sep_next  = 1'b0;
                cw_next   = '0;
                gt_next   = '0;
            end else begin
                hold_next = h_c;
                sep_next  = sep_run;
                cw_next   = cw_reg + SIZE_W'(n_wr);
                gt_next   = gt_new;
            end
        end else if (out_take) begin
            left_next = left_reg - 4'd1;
            idx_next  = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= SIZE_W'(MAX_OUT_SIZE);
            a_valid_reg <= 1'b0;
            hold_reg    <= '0;
            sep_reg     <= 1'b0;
            cw_reg      <= '0;
            gt_reg      <= '0;
            left_reg    <= '0;
            idx_reg     <= '0;
        end else begin
            size_reg    <= size_next;
            a_valid_reg <= a_valid_next;
            hold_reg    <= hold_next;
            sep_reg     <= sep_next;
            cw_reg      <= cw_next;
            gt_reg      <= gt_next;
            left_reg    <= left_next;
            idx_reg     <= idx_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_data_reg <= s_data_byte;
            a_pw_reg   <= s_is_password;
            a_has_reg  <= s_has_byte;
            a_last_reg <= s_last;
        end
        char_reg      <= char_next;
        has_chars_reg <= has_chars_next;
        out_last_reg  <= out_last_next;
        need_reg      <= need_next;
    end

    // The final transaction of an item is the one with a single entry left.
    assign m_valid         = (left_reg != 4'd0);
    assign m_char_valid    = has_chars_reg;
    assign m_out_char      = has_chars_reg ? char_reg[idx_reg] : '0;
    assign m_last_of_run   = (left_reg == 4'd1);
    assign m_needed_length = ((left_reg == 4'd1) && out_last_reg) ? need_reg : '0;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import cb64e_pkg::*;

    // Expected-character ledger. It tracks the encoder's run state on its own
    // and turns every accepted input transaction into the characters that the
    // block must send, in order.
    class credential_encoding_ledger;
        typedef struct {
            logic [CHAR_W-1:0] ch;
            logic              valid;
            logic [NEED_W-1:0] need;
            logic              run_end;
        } enc_char_t;

        enc_char_t         pending_chars[$];
        enc_char_t         batch[$];
        logic [CFG_W-1:0]  size_reg;
        logic [BYTE_W-1:0] held_b0;
        logic [BYTE_W-1:0] held_b1;
        int unsigned       held_n;
        int unsigned       written_n;
        int unsigned       group_n;
        bit                colon_done;
        int unsigned       mismatches;
        int unsigned       inputs_seen;
        int unsigned       chars_seen;
        string             alphabet;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            size_reg = CFG_W'(MAX_OUT_SIZE_DEF);
            mismatches = 0;
            inputs_seen = 0;
            chars_seen = 0;
            restart_run();
        endfunction

        function void restart_run();
            held_b0 = '0;
            held_b1 = '0;
            held_n = 0;
            colon_done = 1'b0;
            written_n = 0;
            group_n = 0;
        endfunction

        function logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
            byte c;
            c = alphabet[v];
            return c[CHAR_W-1:0];
        endfunction

        // A character is kept only while the buffer still has room before
        // its terminator; at most eight characters come from one item.
        function void write_char(input logic [CHAR_W-1:0] c);
            int unsigned room;
            enc_char_t r;
            room = (size_reg > MAX_OUT_SIZE_DEF) ? MAX_OUT_SIZE_DEF : size_reg;
            if (batch.size() >= 8) return;
            if (written_n + 1 < room) begin
                r.ch = c;
                r.valid = 1'b1;
                r.need = '0;
                r.run_end = 1'b0;
                batch.push_back(r);
                written_n++;
            end
        endfunction

        function void encode_group(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                                   input logic [BYTE_W-1:0] b2, input logic [1:0] fill);
            write_char(sextet_char(b0[7:2]));
            write_char(sextet_char({b0[1:0], b1[7:4]}));
            write_char(fill == FILL_TWO ? PAD_CHAR : sextet_char({b1[3:0], b2[7:6]}));
            write_char(fill != FILL_NONE ? PAD_CHAR : sextet_char(b2[5:0]));
            if (group_n < GROUP_MAX) group_n++;
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] b);
            if (held_n >= 2) begin
                encode_group(held_b0, held_b1, b, FILL_NONE);
                held_n = 0;
            end else if (held_n == 1) begin
                held_b1 = b;
                held_n = 2;
            end else begin
                held_b0 = b;
                held_n = 1;
            end
        endfunction

        function void note_input(input logic [BYTE_W-1:0] data, input logic pw,
                                 input logic has, input logic is_last);
            enc_char_t r;
            int unsigned need;
            batch.delete();
            inputs_seen++;
            if (has) begin
                if (pw && !colon_done) begin
                    take_byte(SEP_COLON);
                    colon_done = 1'b1;
                end
                take_byte(data);
            end
            if (is_last) begin
                if (!colon_done && held_n > 0) begin
                    take_byte(SEP_COLON);
                    colon_done = 1'b1;
                end
                if (held_n == 1) encode_group(held_b0, 8'h00, 8'h00, FILL_TWO);
                else if (held_n == 2) encode_group(held_b0, held_b1, 8'h00, FILL_ONE);
                if (batch.size() == 0) begin
                    r.ch = '0;
                    r.valid = 1'b0;
                    r.need = '0;
                    r.run_end = 1'b0;
                    batch.push_back(r);
                end
                need = group_n * 4;
                if (need > NEED_MAX) need = NEED_MAX;
                batch[batch.size()-1].need = NEED_W'(need);
                batch[batch.size()-1].run_end = 1'b1;
                restart_run();
            end else if (batch.size() > 0) begin
                batch[batch.size()-1].run_end = 1'b1;
            end
            foreach (batch[i]) pending_chars.push_back(batch[i]);
        endfunction

        function void field_check(input string what, input logic [15:0] exp_v,
                                  input logic [15:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, what, exp_v, got_v);
            end
        endfunction

        function void check_result(input logic [CHAR_W-1:0] ch, input logic valid,
                                   input logic [NEED_W-1:0] need, input logic run_end);
            enc_char_t e;
            chars_seen++;
            if (pending_chars.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output transaction, expected none, got char 0x%0h",
                         $time, ch);
                return;
            end
            e = pending_chars.pop_front();
            field_check("out_char", 16'(e.ch), 16'(ch));
            field_check("char_valid", 16'(e.valid), 16'(valid));
            field_check("needed_length", 16'(e.need), 16'(need));
            field_check("last_of_run", 16'(e.run_end), 16'(run_end));
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte;
    logic              s_is_password;
    logic              s_has_byte;
    logic              s_last;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CHAR_W-1:0] m_out_char;
    logic              m_char_valid;
    logic [NEED_W-1:0] m_needed_length;
    logic              m_last_of_run;

    // Idle controls for the two sides; clearing them gives a long stretch
    // where both handshakes run back to back.
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    int unsigned driven_items = 0;
    int unsigned settings_done = 0;

    credential_encoding_ledger ledger = new();

    credential_base64_encoder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_is_password   (s_is_password),
        .s_has_byte      (s_has_byte),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_char_valid    (m_char_valid),
        .m_needed_length (m_needed_length),
        .m_last_of_run   (m_last_of_run)
    );

    always #1 aclk = ~aclk;

    // The receiver stalls at random about 29 times in a hundred unless the
    // no-idle stretch is running.
    always @(posedge aclk) begin
        m_ready <= !sink_idle_on || ($urandom_range(0, 99) >= 29);
    end

    // Both channels are sampled at the clock edge, before any register of
    // this edge has updated. Output transactions are checked before the
    // input of the same edge is noted; a result can never belong to an input
    // that is accepted at the same edge, since the block registers its input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                ledger.check_result(m_out_char, m_char_valid, m_needed_length, m_last_of_run);
            end
            if (s_valid && s_ready) begin
                ledger.note_input(s_data_byte, s_is_password, s_has_byte, s_last);
            end
        end
    end

    // Drive one input transaction and hold it until the block takes it. A
    // random gap may come first; s_valid is lowered only when a gap is taken,
    // so a back-to-back transaction never sees valid dropped and raised in
    // one time step.
    task automatic send_item(input logic [BYTE_W-1:0] d, input logic pw,
                             input logic has, input logic is_last);
        if (src_idle_on && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 29);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_is_password <= pw;
        s_has_byte <= has;
        s_last <= is_last;
        do @(posedge aclk); while (!s_ready);
        if (has || is_last) driven_items++;
    endtask

    // Stop sending and wait until every expected character has been taken.
    // The queue is checked only after the monitor has run, so that the last accepted input is noted.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (ledger.pending_chars.size() != 0);
    endtask

    // The size register is only written while the block is idle. Items that
    // give no output may still be in flight when the queue empties, so the
    // task waits further before the write.
    task automatic write_size(input logic [CFG_W-1:0] v);
        drain();
        repeat (6) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.size_reg = v;
        settings_done++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 8'h00;
        if (roll < 16) return 8'hFF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // A well-formed credential: user bytes, then password bytes, with the
    // end marked on the final byte or on a separate flush-only transaction.
    task automatic send_credential();
        int unsigned n_user;
        int unsigned n_pw;
        bit flush_alone;
        n_user = $urandom_range(0, 7);
        n_pw = $urandom_range(0, 7);
        flush_alone = ($urandom_range(0, 2) == 0) || (n_user + n_pw == 0);
        for (int k = 0; k < n_user; k++) begin
            send_item(pick_byte(), 1'b0, 1'b1, !flush_alone && n_pw == 0 && k == n_user - 1);
        end
        for (int k = 0; k < n_pw; k++) begin
            send_item(pick_byte(), 1'b1, 1'b1, !flush_alone && k == n_pw - 1);
        end
        if (flush_alone) begin
            send_item(pick_byte(), 1'(($urandom_range(0, 1))), 1'b0, 1'b1);
        end
    endtask

    // One phase of random traffic at a given buffer size: mostly complete
    // credentials, the rest single transactions with every field random,
    // which also covers user bytes after password bytes.
    task automatic run_phase(input logic [CFG_W-1:0] size_v, input int unsigned quota,
                             input bit pause_midway);
        int unsigned start;
        bit paused;
        write_size(size_v);
        start = driven_items;
        paused = 1'b0;
        while (driven_items - start < quota) begin
            if ($urandom_range(0, 99) < 80) begin
                send_credential();
            end else begin
                send_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
            end
            if (pause_midway && !paused && driven_items - start >= quota / 2) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_data_byte <= '0;
        s_is_password <= 1'b0;
        s_has_byte <= 1'b0;
        s_last <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset size. An empty run first: one
        // transaction with char_valid low and a zero length.
        send_item(8'h00, 1'b0, 1'b0, 1'b1);
        // Three user bytes fill a group exactly, so the end adds no
        // separator and only reports the length.
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1, 1'b0);
        send_item(8'h80, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b1);
        // The separator lands before the first password byte, which completes a
        // group; the final byte is padded with two '=' characters.
        send_item(8'hFF, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        // No password: the separator is added at the end, one '=' of padding.
        send_item(8'h41, 1'b0, 1'b1, 1'b1);
        // Password first, then a user byte that is encoded as plain data.
        send_item(8'h7F, 1'b1, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1, 1'b0);
        // Flush-only transactions without the end mark give nothing.
        send_item(8'hA5, 1'b0, 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0, 1'b0);
        send_item(8'hAA, 1'b1, 1'b1, 1'b1);
        // Two user bytes ended alone: the separator completes the group.
        send_item(8'h01, 1'b0, 1'b1, 1'b0);
        send_item(8'hFE, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0, 1'b1);

        // Random phases over the buffer sizes: tiny ones that drop most characters,
        // zero, the largest register value, a middle and a random size, and the default.
        run_phase(CFG_W'(5), 60, 1'b0);
        run_phase(CFG_W'(2), 60, 1'b0);
        run_phase(CFG_W'(0), 60, 1'b1);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        run_phase(CFG_W'(8191), 60, 1'b0);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        run_phase(CFG_W'(13), 60, 1'b0);
        run_phase(CFG_W'($urandom_range(1, 4096)), 60, 1'b0);
        run_phase(CFG_W'(MAX_OUT_SIZE_DEF), 60, 1'b0);

        drain();
        repeat (12) @(posedge aclk);
        $display("Run covered %0d input transactions and %0d output characters",
                 ledger.inputs_seen, ledger.chars_seen);
        $display("over %0d buffer-size settings, from zero up past the largest size.",
                 settings_done);
        if (ledger.mismatches == 0) begin
            $display("credential_base64_encoder_core verification clean");
        end else begin
            $display("credential_base64_encoder_core verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Timeout with %0d characters still expected", ledger.pending_chars.size());
        $display("credential_base64_encoder_core verification failed");
        $finish;
    end

endmodule
